/* design/fdmd_pkg.sv */
// ----------------------------------------------------------------------------
// fdmd_pkg
// shared constants and types of the frame difference motion detector
// ----------------------------------------------------------------------------
package fdmd_pkg;

   localparam int FRAME_PIXELS = 76800;
   localparam int ADDR_W       = $clog2(FRAME_PIXELS);
   localparam int POS_W        = $clog2(FRAME_PIXELS + 1);
   localparam int LUMA_W       = 8;
   localparam int COUNT_W      = 17;
   localparam int WARM_W       = 3;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_DIFF_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOTION_THRESHOLD     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_WARMUP       = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REARM_WARMUP         = 8'd3;

   localparam logic [LUMA_W-1:0]  RST_PIXEL_DIFF_THRESHOLD = 8'd10;
   localparam logic [COUNT_W-1:0] RST_MOTION_THRESHOLD     = 17'd1000;
   localparam logic [WARM_W-1:0]  RST_INITIAL_WARMUP       = 3'd4;
   localparam logic [WARM_W-1:0]  RST_REARM_WARMUP         = 3'd3;

   typedef struct packed {
      logic [LUMA_W-1:0]  pixel_diff_threshold;
      logic [COUNT_W-1:0] motion_threshold;
      logic [WARM_W-1:0]  initial_warmup;
      logic [WARM_W-1:0]  rearm_warmup;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              frame_end;
      logic              in_range;
      logic [LUMA_W-1:0] luma;
   } beat_type;

endpackage

/* design/fdmd_frame_store.sv */
// ----------------------------------------------------------------------------
// fdmd_frame_store
// previous frame memory, pixel position and the stage register after it
// ----------------------------------------------------------------------------
module fdmd_frame_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [fdmd_pkg::LUMA_W-1:0]   req_luma,
   input  logic                          req_frame_end,
   output logic                          req_stall,
   input  logic                          beat_adv,
   output fdmd_pkg::beat_type            beat,
   output logic [fdmd_pkg::LUMA_W-1:0]   old_luma
);

   logic [fdmd_pkg::LUMA_W-1:0] mem [fdmd_pkg::FRAME_PIXELS];

   logic [fdmd_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [fdmd_pkg::LUMA_W-1:0] rd_ff;
   fdmd_pkg::beat_type          beat_ff, beat_in;
   logic                        accept;
   logic                        in_range;

   assign req_stall = beat_ff.valid && !beat_adv;
   assign accept    = req_valid && !req_stall;
   assign in_range  = pos_ff < fdmd_pkg::POS_W'(fdmd_pkg::FRAME_PIXELS);

   always_comb begin
      pos_in  = pos_ff;
      beat_in = beat_ff;
      if (accept) begin
         if (req_frame_end) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + 1'b1;
         end
         beat_in.valid     = 1'b1;
         beat_in.frame_end = req_frame_end;
         beat_in.in_range  = in_range;
         beat_in.luma      = req_luma;
      end else if (beat_adv) begin
         beat_in.valid = 1'b0;
      end
   end

   // read first, so the old pixel comes out while the new one goes in
   always_ff @(posedge clock) begin
      if (accept && in_range) begin
         rd_ff <= mem[pos_ff[fdmd_pkg::ADDR_W-1:0]];
         mem[pos_ff[fdmd_pkg::ADDR_W-1:0]] <= req_luma;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         beat_ff.valid <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.frame_end <= beat_in.frame_end;
      beat_ff.in_range  <= beat_in.in_range;
      beat_ff.luma      <= beat_in.luma;
   end

   assign beat     = beat_ff;
   assign old_luma = rd_ff;

endmodule

/* design/fdmd_compare.sv */
// ----------------------------------------------------------------------------
// fdmd_compare
// pixel difference, changed count, warm-up control and result register
// ----------------------------------------------------------------------------
module fdmd_compare (
   input  logic                          clock,
   input  logic                          reset,
   input  fdmd_pkg::cfg_type             cfg,
   input  fdmd_pkg::beat_type            beat,
   input  logic [fdmd_pkg::LUMA_W-1:0]   old_luma,
   output logic                          beat_adv,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_compared,
   output logic                          rsp_motion,
   output logic [fdmd_pkg::COUNT_W-1:0]  rsp_changed_count
);

   logic [fdmd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         first_ff, first_in;
   logic [fdmd_pkg::WARM_W-1:0]  warm_ff, warm_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         compared_ff, compared_in;
   logic                         motion_ff, motion_in;
   logic [fdmd_pkg::COUNT_W-1:0] changed_ff, changed_in;

   logic [fdmd_pkg::LUMA_W-1:0]  diff;
   logic                         comparing;
   logic                         hit;
   logic [fdmd_pkg::COUNT_W-1:0] count_sum;
   logic                         take;

   assign diff      = (beat.luma > old_luma) ? beat.luma - old_luma : old_luma - beat.luma;
   assign comparing = !first_ff && (warm_ff == '0);
   assign hit       = beat.in_range && comparing && (diff > cfg.pixel_diff_threshold);
   assign count_sum = count_ff + fdmd_pkg::COUNT_W'(hit);
   assign beat_adv  = !(beat.frame_end && rsp_valid_ff && rsp_stall);
   assign take      = beat.valid && beat_adv;

   always_comb begin
      count_in     = count_ff;
      first_in     = first_ff;
      warm_in      = warm_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      compared_in  = compared_ff;
      motion_in    = motion_ff;
      changed_in   = changed_ff;
      if (take) begin
         if (beat.frame_end) begin
            count_in     = '0;
            rsp_valid_in = 1'b1;
            compared_in  = 1'b0;
            motion_in    = 1'b0;
            changed_in   = '0;
            if (first_ff) begin
               first_in = 1'b0;
               warm_in  = (cfg.initial_warmup != '0) ? cfg.initial_warmup - 1'b1 : '0;
            end else if (warm_ff != '0) begin
               warm_in = warm_ff - 1'b1;
            end else begin
               compared_in = 1'b1;
               changed_in  = count_sum;
               if (count_sum > cfg.motion_threshold) begin
                  motion_in = 1'b1;
                  warm_in   = cfg.rearm_warmup;
               end
            end
         end else begin
            count_in = count_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         first_ff     <= 1'b1;
         warm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         first_ff     <= first_in;
         warm_ff      <= warm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      compared_ff <= compared_in;
      motion_ff   <= motion_in;
      changed_ff  <= changed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compared      = compared_ff;
   assign rsp_motion        = motion_ff;
   assign rsp_changed_count = changed_ff;

endmodule

/* design/frame_difference_motion_detector_core.sv */
// ----------------------------------------------------------------------------
// frame_difference_motion_detector_core
// a frame-end pixel goes through the stage register, then the result register
// throughput: one pixel per cycle unless stalled, set by the single read-first
// frame memory port; the result register lets pixels flow while a result waits,
// only a second frame end stalls behind it
// reset clears position, counts and warm-up state, registers to defaults;
// the frame memory is not cleared and holds anything until written
// ----------------------------------------------------------------------------
module frame_difference_motion_detector_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fdmd_pkg::LUMA_W-1:0]      req_luma,
   input  logic                             req_frame_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_compared,
   output logic                             rsp_motion,
   output logic [fdmd_pkg::COUNT_W-1:0]     rsp_changed_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fdmd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdmd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fdmd_pkg::cfg_type           cfg_ff, cfg_in;
   fdmd_pkg::beat_type          beat;
   logic [fdmd_pkg::LUMA_W-1:0] old_luma;
   logic                        beat_adv;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            fdmd_pkg::REG_PIXEL_DIFF_THRESHOLD: begin
               cfg_in.pixel_diff_threshold = csr_wdata[fdmd_pkg::LUMA_W-1:0];
            end
            fdmd_pkg::REG_MOTION_THRESHOLD: begin
               cfg_in.motion_threshold = csr_wdata[fdmd_pkg::COUNT_W-1:0];
            end
            fdmd_pkg::REG_INITIAL_WARMUP: begin
               cfg_in.initial_warmup = csr_wdata[fdmd_pkg::WARM_W-1:0];
            end
            fdmd_pkg::REG_REARM_WARMUP: begin
               cfg_in.rearm_warmup = csr_wdata[fdmd_pkg::WARM_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_diff_threshold <= fdmd_pkg::RST_PIXEL_DIFF_THRESHOLD;
         cfg_ff.motion_threshold     <= fdmd_pkg::RST_MOTION_THRESHOLD;
         cfg_ff.initial_warmup       <= fdmd_pkg::RST_INITIAL_WARMUP;
         cfg_ff.rearm_warmup         <= fdmd_pkg::RST_REARM_WARMUP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fdmd_frame_store u_store (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_luma      (req_luma),
      .req_frame_end (req_frame_end),
      .req_stall     (req_stall),
      .beat_adv      (beat_adv),
      .beat          (beat),
      .old_luma      (old_luma)
   );

   fdmd_compare u_compare (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .beat              (beat),
      .old_luma          (old_luma),
      .beat_adv          (beat_adv),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compared      (rsp_compared),
      .rsp_motion        (rsp_motion),
      .rsp_changed_count (rsp_changed_count)
   );

   // motion only on a compared frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_motion || rsp_compared))
      else $error("motion without comparison");

   // frames not compared carry no count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_compared) |-> (rsp_changed_count == '0))
      else $error("count on a frame that was not compared");

   // input only backs up behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no result waiting");

endmodule
